/* rtl/assert_macros.svh */
// Assertion macros for the RTL files; only dctm_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/dctm_pkg.sv */
`timescale 1ns / 1ps
package dctm_pkg;

  localparam int SAMPLE_W = 10;
  localparam int MEAN_W = 10;
  localparam int VALUE_W = 14;

  localparam logic CH_VOLT = 1'b0;
  localparam logic CH_CURR = 1'b1;

  localparam logic [VALUE_W-1:0] LIMIT_RESET = 14'd8000;

  localparam int CURR_SHIFT = 4;

  // Exact reciprocals for the voltage scaling of a 10-bit mean.
  localparam int RECIP_W = 12;
  localparam int RECIP3_S = 13;
  localparam logic [RECIP_W-1:0] RECIP3 = 12'd2731;
  localparam int RECIP5_S = 14;
  localparam logic [RECIP_W-1:0] RECIP5 = 12'd3277;

endpackage

/* rtl/dctm_front.sv */
`timescale 1ns / 1ps
module dctm_front import dctm_pkg::*; #(
  parameter int SAMPLES_PER_GROUP = 4,
  localparam int SUM_W = $clog2(((1 << SAMPLE_W) - 1) * SAMPLES_PER_GROUP + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                channel,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic                q_full,
  output logic                q_push,
  output logic                q_channel,
  output logic [SUM_W-1:0]    q_sum
);

  localparam int CNT_W = $clog2(SAMPLES_PER_GROUP);

  logic [SUM_W-1:0] acc [2];
  logic [CNT_W-1:0] cnt [2];
  logic [SUM_W-1:0] acc_next;
  logic             accept;
  logic             last;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign acc_next  = acc[channel] + SUM_W'(sample);
  assign last      = cnt[channel] == CNT_W'(SAMPLES_PER_GROUP - 1);
  assign q_push    = accept && last;
  assign q_channel = channel;
  assign q_sum     = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        acc[i] <= '0;
        cnt[i] <= '0;
      end
    end else if (accept) begin
      if (last) begin
        acc[channel] <= '0;
        cnt[channel] <= '0;
      end else begin
        acc[channel] <= acc_next;
        cnt[channel] <= cnt[channel] + CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/dctm_queue.sv */
`timescale 1ns / 1ps
module dctm_queue #(
  parameter int DATA_W = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= push_data;
        wr_ptr       <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/dctm_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dctm_back import dctm_pkg::*; #(
  parameter int SAMPLES_PER_GROUP = 4,
  parameter int GROUP_COUNT = 4,
  localparam int SUM_W = $clog2(((1 << SAMPLE_W) - 1) * SAMPLES_PER_GROUP + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic               q_channel,
  input  logic [SUM_W-1:0]   q_sum,
  input  logic [VALUE_W-1:0] limit,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_channel,
  output logic [VALUE_W-1:0] scaled_value,
  output logic               over_current
);

  localparam int IDX_W = $clog2(GROUP_COUNT);

  localparam int MEAN_S = SUM_W + $clog2(SAMPLES_PER_GROUP) + 1;
  localparam int MEAN_M_W = MEAN_S + 1;
  localparam int MEAN_M = ((1 << MEAN_S) + SAMPLES_PER_GROUP - 1) / SAMPLES_PER_GROUP;
  localparam logic [MEAN_M_W-1:0] MEAN_MK = MEAN_M_W'(MEAN_M);
  localparam int PROD_W = SUM_W + MEAN_M_W;

  localparam int TRIM_D = GROUP_COUNT - 2;
  localparam int TOT_W = $clog2(((1 << MEAN_W) - 1) * TRIM_D + 1);
  localparam int TRIM_S = TOT_W + $clog2(TRIM_D) + 1;
  localparam int TRIM_M_W = TRIM_S + 1;
  localparam int TRIM_M = ((1 << TRIM_S) + TRIM_D - 1) / TRIM_D;
  localparam logic [TRIM_M_W-1:0] TRIM_MK = TRIM_M_W'(TRIM_M);
  localparam int TPROD_W = TOT_W + TRIM_M_W;

  localparam int SCL_W = MEAN_W + RECIP_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GROUP_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_SCAN,
    ST_SUM,
    ST_DIV,
    ST_TRIM,
    ST_SCALE,
    ST_OUT
  } state_t;

  state_t             state;
  logic               chan_r;
  logic [PROD_W-1:0]  mean_prod;
  logic [IDX_W-1:0]   grp_idx [2];
  logic [MEAN_W-1:0]  means [2][GROUP_COUNT];
  logic [IDX_W-1:0]   k;
  logic [IDX_W-1:0]   hi_idx;
  logic [IDX_W-1:0]   lo_idx;
  logic [MEAN_W-1:0]  hi_val;
  logic [MEAN_W-1:0]  lo_val;
  logic [MEAN_W-1:0]  tmean;
  logic [TOT_W-1:0]   total;
  logic [TPROD_W-1:0] trim_prod;
  logic [SCL_W-1:0]   p3;
  logic [SCL_W-1:0]   p5;
  logic [MEAN_W-1:0]  m_k;
  logic [MEAN_W-1:0]  mean_new;
  logic [VALUE_W-1:0] volt_value;
  logic [VALUE_W-1:0] curr_value;

  assign q_pop      = (state == ST_IDLE) && q_valid;
  assign m_k        = means[chan_r][k];
  assign mean_new   = mean_prod[MEAN_S +: MEAN_W];
  assign volt_value = VALUE_W'(tmean) + VALUE_W'(p3 >> RECIP3_S) + VALUE_W'(p5 >> RECIP5_S);
  assign curr_value = VALUE_W'(tmean) << CURR_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      grp_idx[0] <= '0;
      grp_idx[1] <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            chan_r    <= q_channel;
            mean_prod <= q_sum * MEAN_MK;
            state     <= ST_STORE;
          end
        end
        ST_STORE: begin
          means[chan_r][grp_idx[chan_r]] <= mean_new;
          if (grp_idx[chan_r] == LAST_IDX) begin
            grp_idx[chan_r] <= '0;
            k      <= IDX_W'(1);
            hi_idx <= '0;
            lo_idx <= '0;
            hi_val <= means[chan_r][0];
            lo_val <= means[chan_r][0];
            state  <= ST_SCAN;
          end else begin
            grp_idx[chan_r] <= grp_idx[chan_r] + IDX_W'(1);
            state           <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (m_k > hi_val) begin
            hi_idx <= k;
            hi_val <= m_k;
          end
          if (m_k < lo_val) begin
            lo_idx <= k;
            lo_val <= m_k;
          end
          if (k == LAST_IDX) begin
            k     <= '0;
            total <= '0;
            state <= ST_SUM;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        ST_SUM: begin
          if (k != hi_idx && k != lo_idx) begin
            total <= total + TOT_W'(m_k);
          end
          if (k == LAST_IDX) begin
            if (hi_idx == lo_idx) begin
              tmean <= hi_val;
              state <= ST_SCALE;
            end else begin
              state <= ST_DIV;
            end
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        ST_DIV: begin
          trim_prod <= total * TRIM_MK;
          state     <= ST_TRIM;
        end
        ST_TRIM: begin
          tmean <= trim_prod[TRIM_S +: MEAN_W];
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          p3    <= tmean * RECIP3;
          p5    <= tmean * RECIP5;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            result_channel <= chan_r;
            if (chan_r == CH_CURR) begin
              scaled_value <= curr_value;
              over_current <= curr_value > limit;
            end else begin
              scaled_value <= volt_value;
              over_current <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_volt_no_flag, clk, rst, out_valid && (result_channel == CH_VOLT), !over_current, "voltage result carries over-current flag")
  `ASSERT_IMPL(a_walk_range, clk, rst, (state == ST_SCAN) || (state == ST_SUM), k <= LAST_IDX, "group walk index out of range")
  `ASSERT_IMPL(a_trim_order, clk, rst, state == ST_SUM, hi_val >= lo_val, "largest mean below smallest mean")
  `ASSERT_NEXT(a_pop_store, clk, rst, q_pop, state == ST_STORE, "popped group sum not stored")

endmodule

/* rtl/dual_channel_trimmed_mean_adc.sv */
`timescale 1ns / 1ps
// Path: with an idle back end, a sample that completes a set of group means is pushed into the
// queue, then the back end steps through IDLE, STORE, SCAN, SUM, DIV, TRIM, SCALE and OUT to raise
// out_valid; DIV and TRIM are skipped when all means are equal. Throughput: one sample beat per cycle
// while the two-entry group queue has room; the back end walks the means serially and pops no sums.
// Reset is synchronous and clears accumulators, counts, group indexes, the queue and out_valid,
// and sets the limit to 8000; group means need no clearing.
module dual_channel_trimmed_mean_adc import dctm_pkg::*; #(
  parameter int SAMPLES_PER_GROUP = 4,
  parameter int GROUP_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               channel,
  input  logic [SAMPLE_W-1:0] sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               result_channel,
  output logic [VALUE_W-1:0] scaled_value,
  output logic               over_current,
  input  logic               cfg_wr_en,
  input  logic [VALUE_W-1:0] cfg_wr_data
);

  localparam int SUM_W = $clog2(((1 << SAMPLE_W) - 1) * SAMPLES_PER_GROUP + 1);

  logic [VALUE_W-1:0] limit;
  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  logic               push_channel;
  logic [SUM_W-1:0]   push_sum;
  logic [SUM_W:0]     pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit <= cfg_wr_data;
    end
  end

  dctm_front #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .channel  (channel),
    .sample   (sample),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_channel(push_channel),
    .q_sum    (push_sum)
  );

  dctm_queue #(
    .DATA_W(SUM_W + 1)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data({push_channel, push_sum}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  dctm_back #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .GROUP_COUNT      (GROUP_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (!q_empty),
    .q_pop         (q_pop),
    .q_channel     (pop_data[SUM_W]),
    .q_sum         (pop_data[SUM_W-1:0]),
    .limit         (limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_channel(result_channel),
    .scaled_value  (scaled_value),
    .over_current  (over_current)
  );

endmodule

/* test/dctm_result_checker.sv */
`timescale 1ns / 1ps
module dctm_result_checker import dctm_pkg::*; #(
  parameter int SAMPLES_PER_GROUP = 4,
  parameter int GROUP_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               channel,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               result_channel,
  input  logic [VALUE_W-1:0] scaled_value,
  input  logic               over_current,
  input  logic               cfg_wr_en,
  input  logic [VALUE_W-1:0] cfg_wr_data,
  output int                 error_count,
  output int                 pending_count,
  output int                 result_count
);

  typedef struct packed {
    logic               chan;
    logic [VALUE_W-1:0] value;
    logic               flag;
  } adc_result_t;

  adc_result_t expected_results[$];
  logic [VALUE_W-1:0] limit_reg;
  int group_sum [2];
  int sums_taken [2];
  int groups_done [2];
  logic [MEAN_W-1:0] group_means [2][GROUP_COUNT];
  int errors;
  int results;

  function automatic logic [MEAN_W-1:0] trimmed_mean_of(input int c);
    int hi;
    int lo;
    int total;
    hi = 0;
    lo = 0;
    total = 0;
    for (int k = 1; k < GROUP_COUNT; k++) begin
      if (group_means[c][k] > group_means[c][hi]) hi = k;
      if (group_means[c][k] < group_means[c][lo]) lo = k;
    end
    if (hi == lo) return group_means[c][hi];
    for (int k = 0; k < GROUP_COUNT; k++) begin
      if (k != hi && k != lo) total += int'(group_means[c][k]);
    end
    return MEAN_W'(total / (GROUP_COUNT - 2));
  endfunction

  function automatic void absorb_sample(input logic ch, input logic [SAMPLE_W-1:0] smp);
    int c;
    int m;
    adc_result_t r;
    c = (ch == CH_CURR) ? 1 : 0;
    group_sum[c] += int'(smp);
    sums_taken[c]++;
    if (sums_taken[c] < SAMPLES_PER_GROUP) return;
    sums_taken[c] = 0;
    group_means[c][groups_done[c]] = MEAN_W'(group_sum[c] / SAMPLES_PER_GROUP);
    group_sum[c] = 0;
    groups_done[c]++;
    if (groups_done[c] < GROUP_COUNT) return;
    groups_done[c] = 0;
    m = int'(trimmed_mean_of(c));
    r.chan = ch;
    if (ch == CH_VOLT) begin
      r.value = VALUE_W'(m + m / 3 + m / 5);
      r.flag = 1'b0;
    end else begin
      r.value = VALUE_W'(m << CURR_SHIFT);
      r.flag = (r.value > limit_reg);
    end
    expected_results.push_back(r);
  endfunction

  function automatic void check_result();
    adc_result_t e;
    results++;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat, expected none, actual channel %0d value %0d flag %0d",
               $time, result_channel, scaled_value, over_current);
      return;
    end
    e = expected_results.pop_front();
    if (result_channel !== e.chan) begin
      errors++;
      $display("%0t: result_channel mismatch, expected %0d, actual %0d",
               $time, e.chan, result_channel);
    end
    if (scaled_value !== e.value) begin
      errors++;
      $display("%0t: scaled_value mismatch, expected %0d, actual %0d",
               $time, e.value, scaled_value);
    end
    if (over_current !== e.flag) begin
      errors++;
      $display("%0t: over_current mismatch, expected %0d, actual %0d",
               $time, e.flag, over_current);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      limit_reg = LIMIT_RESET;
      expected_results.delete();
      for (int c = 0; c < 2; c++) begin
        group_sum[c] = 0;
        sums_taken[c] = 0;
        groups_done[c] = 0;
        for (int k = 0; k < GROUP_COUNT; k++) group_means[c][k] = '0;
      end
    end else begin
      if (cfg_wr_en) limit_reg = cfg_wr_data;
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) absorb_sample(channel, sample);
    end
    error_count <= errors;
    pending_count <= expected_results.size();
    result_count <= results;
  end

endmodule

/* test/tb_dual_channel_trimmed_mean_adc.sv */
`timescale 1ns / 1ps
module tb_dual_channel_trimmed_mean_adc;
  import dctm_pkg::*;

  localparam int SAMPLES_PER_GROUP = 4;
  localparam int GROUP_COUNT = 4;
  localparam int SET_LEN = SAMPLES_PER_GROUP * GROUP_COUNT;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_WAIT = 13;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic channel = 1'b0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic out_ready = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [VALUE_W-1:0] cfg_wr_data = '0;
  wire in_ready;
  wire out_valid;
  wire result_channel;
  wire [VALUE_W-1:0] scaled_value;
  wire over_current;

  int error_count;
  int pending_count;
  int result_count;

  int gap_next = 0;
  bit quiet = 1'b0;
  logic rx_quiet = 1'b0;
  int rx_wait;
  int samples_sent = 0;
  int settings_used = 1;
  int set_pos [2] = '{0, 0};
  int set_mode [2] = '{0, 0};
  logic [SAMPLE_W-1:0] set_level [2];
  logic [VALUE_W-1:0] limit_now = LIMIT_RESET;

  dual_channel_trimmed_mean_adc #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .GROUP_COUNT(GROUP_COUNT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .channel(channel),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_channel(result_channel),
    .scaled_value(scaled_value),
    .over_current(over_current),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  dctm_result_checker #(
    .SAMPLES_PER_GROUP(SAMPLES_PER_GROUP),
    .GROUP_COUNT(GROUP_COUNT)
  ) result_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .channel(channel),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_channel(result_channel),
    .scaled_value(scaled_value),
    .over_current(over_current),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .error_count(error_count),
    .pending_count(pending_count),
    .result_count(result_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst) begin
      rx_wait = int'($urandom_range(0, MAX_WAIT));
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      rx_wait = rx_quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
      out_ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= (rx_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic ch, input logic [SAMPLE_W-1:0] smp);
    repeat (gap_next) @(posedge clk);
    in_valid <= 1'b1;
    channel <= ch;
    sample <= smp;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    gap_next = quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
    if (gap_next != 0) in_valid <= 1'b0;
  endtask

  task automatic drain();
    if (gap_next == 0) in_valid <= 1'b0;
    gap_next = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [VALUE_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    limit_now = v;
    settings_used++;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int c);
    int center;
    logic [SAMPLE_W-1:0] v;
    if (set_pos[c] == 0) begin
      set_mode[c] = int'($urandom_range(0, 3));
      set_level[c] = SAMPLE_W'($urandom);
    end
    set_pos[c] = (set_pos[c] + 1) % SET_LEN;
    case (set_mode[c])
      0: v = SAMPLE_W'($urandom);
      1: v = set_level[c];
      2: begin
        center = (c == 1) ? int'(limit_now >> CURR_SHIFT) : int'(set_level[c]);
        center += int'($urandom_range(0, 4)) - 2;
        if (center < 0) center = 0;
        if (center > 1023) center = 1023;
        v = SAMPLE_W'(center);
      end
      default: v = $urandom_range(0, 1) ? '1 : '0;
    endcase
    return v;
  endfunction

  task automatic run_random(input int n);
    int c;
    for (int k = 0; k < n; k++) begin
      quiet = (k % 60) >= 45;
      rx_quiet <= quiet;
      c = int'($urandom_range(0, 1));
      send_sample(c ? CH_CURR : CH_VOLT, pick_sample(c));
    end
  endtask

  function automatic logic [VALUE_W-1:0] planned_limit(input int p);
    case (p)
      0: return '0;
      1: return '1;
      2: return 14'd16368;
      3: return 14'd16367;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Voltage means 1023, 0, 1023, 0 tie on both ends; current means are all equal.
    for (int k = 0; k < SET_LEN; k++) begin
      send_sample(CH_VOLT, ((k / SAMPLES_PER_GROUP) % 2 == 0) ? 10'd1023 : 10'd0);
    end
    for (int k = 0; k < SET_LEN; k++) send_sample(CH_CURR, 10'd1023);

    run_random(110);
    for (int p = 0; p < 5; p++) begin
      drain();
      write_limit(planned_limit(p));
      run_random(108);
    end
    drain();

    $display("Summary: %0d sample beats on both channels, %0d result beats checked.",
             samples_sent, result_count);
    $display("Summary: %0d over-current limit settings, including 0 and full scale.",
             settings_used);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
